FILE: hw/rtl/pcpe_pkg.sv
// pcpe_pkg: shared widths, byte codes and the sequencer state type for the
// column post encoder. No dependencies.

package pcpe_pkg;

    localparam int MAX_HEIGHT_DEF = 32;
    localparam int PIX_W          = 8;
    localparam int ROW_W          = 6;

    localparam logic [PIX_W-1:0] PAD_BYTE  = 8'h00;
    localparam logic [PIX_W-1:0] TERM_BYTE = 8'hff;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR_ROW,
        ST_HDR_LEN,
        ST_PAD0,
        ST_DATA,
        ST_PAD1,
        ST_TERM
    } t_state;

endpackage

FILE: hw/rtl/pcpe_if.sv
// pcpe_if: valid/ready channel interfaces for the pixel input and the byte
// output of the column post encoder. Depends on pcpe_pkg.

interface pcpe_in_if;
    logic                       valid;
    logic                       ready;
    logic [pcpe_pkg::PIX_W-1:0] colour_index;
    logic                       transparent;
    logic                       last_in_column;

    modport source (output valid, output colour_index, output transparent,
                    output last_in_column, input ready);
    modport sink   (input valid, input colour_index, input transparent,
                    input last_in_column, output ready);
endinterface

interface pcpe_out_if;
    logic                       valid;
    logic                       ready;
    logic [pcpe_pkg::PIX_W-1:0] out_byte;
    logic                       end_of_burst;
    logic                       end_of_column;

    modport source (output valid, output out_byte, output end_of_burst,
                    output end_of_column, input ready);
    modport sink   (input valid, input out_byte, input end_of_burst,
                    input end_of_column, output ready);
endinterface

FILE: hw/rtl/pcpe_pixel_ram.sv
// pcpe_pixel_ram: buffer for the indices of the open post, one write port and
// one registered read port with read enable. Depends on pcpe_pkg.

module pcpe_pixel_ram #(
    parameter int DEPTH = pcpe_pkg::MAX_HEIGHT_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [pcpe_pkg::PIX_W-1:0] i_wr_data,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [pcpe_pkg::PIX_W-1:0] o_rd_data
);

    logic [pcpe_pkg::PIX_W-1:0] r_mem [DEPTH];
    logic [pcpe_pkg::PIX_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds while the consumer stalls
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/patch_column_post_encoder.sv
// patch_column_post_encoder: top level, pixel sequencer, post buffer and
// output register. Depends on pcpe_pkg, pcpe_if and pcpe_pixel_ram.
//
//   channel   dir  handshake            payload
//   i_pix     in   valid/ready (sink)   colour_index[7:0] transparent last_in_column
//   o_byte    out  valid/ready (source) out_byte[7:0] end_of_burst end_of_column
//
// an opaque pixel that does not end the column leaves the sequencer idle; a pixel
// that closes a post of L pixels emits the start row, the length, a pad byte, the
// L indices and a pad byte, then the 0xff terminator at column end; the output
// register moves one byte a cycle unless stalled; i_pix.ready is high only while
// the sequencer is idle; a stalled output holds sequencer and buffer read in place
// synchronous active-low reset clears the control state, no clearing pass

module patch_column_post_encoder #(
    parameter int MAX_HEIGHT = pcpe_pkg::MAX_HEIGHT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pcpe_in_if.sink        i_pix,
    pcpe_out_if.source     o_byte
);

    localparam int AW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam logic [pcpe_pkg::ROW_W-1:0] LAST_ROW = pcpe_pkg::ROW_W'(MAX_HEIGHT - 1);
    localparam logic [pcpe_pkg::ROW_W-1:0] MAX_LEN  = pcpe_pkg::ROW_W'(MAX_HEIGHT);

    pcpe_pkg::t_state r_state, n_state;

    logic [pcpe_pkg::ROW_W-1:0] r_row,   n_row;
    logic [pcpe_pkg::ROW_W-1:0] r_start, n_start;
    logic [pcpe_pkg::ROW_W-1:0] r_len,   n_len;
    logic [pcpe_pkg::ROW_W-1:0] r_idx,   n_idx;
    logic                       r_in_run, n_in_run;
    logic                       r_term,   n_term;

    logic                       r_out_valid;
    logic [pcpe_pkg::PIX_W-1:0] r_out_byte;
    logic                       r_out_eob;
    logic                       r_out_eoc;

    logic                       accept;
    logic                       load;
    logic                       last_eff;
    logic                       post_closes;
    logic [pcpe_pkg::ROW_W-1:0] idx_nxt;

    logic                       emit;
    logic [pcpe_pkg::PIX_W-1:0] e_byte;
    logic                       e_eob;
    logic                       e_eoc;

    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic [pcpe_pkg::PIX_W-1:0] rd_data;

    pcpe_pixel_ram #(
        .DEPTH (MAX_HEIGHT),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_pix.colour_index),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign i_pix.ready = (r_state == pcpe_pkg::ST_IDLE);
    assign accept      = i_pix.valid && i_pix.ready;
    assign load        = !r_out_valid || o_byte.ready;

    // a pixel on the last allowed row closes the column regardless
    assign last_eff    = i_pix.last_in_column || (r_row >= LAST_ROW);
    assign post_closes = (i_pix.transparent && r_in_run) ||
                         (!i_pix.transparent && last_eff);
    assign idx_nxt     = r_idx + pcpe_pkg::ROW_W'(1);

    always_comb begin
        n_state  = r_state;
        n_row    = r_row;
        n_start  = r_start;
        n_len    = r_len;
        n_idx    = r_idx;
        n_in_run = r_in_run;
        n_term   = r_term;
        wr_en    = 1'b0;
        wr_addr  = r_len[AW-1:0];
        rd_en    = 1'b0;
        rd_addr  = '0;
        emit     = 1'b0;
        e_byte   = pcpe_pkg::PAD_BYTE;
        e_eob    = 1'b0;
        e_eoc    = 1'b0;

        unique case (r_state)
            pcpe_pkg::ST_IDLE: begin
                if (accept) begin
                    if (!i_pix.transparent) begin
                        if (!r_in_run) begin
                            n_in_run = 1'b1;
                            n_start  = r_row;
                            wr_en    = 1'b1;
                            wr_addr  = '0;
                            n_len    = pcpe_pkg::ROW_W'(1);
                        end else if (r_len < MAX_LEN) begin
                            wr_en    = 1'b1;
                            n_len    = r_len + pcpe_pkg::ROW_W'(1);
                        end
                    end
                    n_row  = last_eff ? '0 : r_row + pcpe_pkg::ROW_W'(1);
                    n_term = last_eff;
                    if (post_closes) begin
                        n_state = pcpe_pkg::ST_HDR_ROW;
                    end else if (last_eff) begin
                        n_state = pcpe_pkg::ST_TERM;
                    end
                end
            end
            pcpe_pkg::ST_HDR_ROW: begin
                if (load) begin
                    emit    = 1'b1;
                    e_byte  = {{(pcpe_pkg::PIX_W - pcpe_pkg::ROW_W){1'b0}}, r_start};
                    n_state = pcpe_pkg::ST_HDR_LEN;
                end
            end
            pcpe_pkg::ST_HDR_LEN: begin
                if (load) begin
                    emit    = 1'b1;
                    e_byte  = {{(pcpe_pkg::PIX_W - pcpe_pkg::ROW_W){1'b0}}, r_len};
                    n_state = pcpe_pkg::ST_PAD0;
                end
            end
            pcpe_pkg::ST_PAD0: begin
                if (load) begin
                    emit    = 1'b1;
                    rd_en   = 1'b1;
                    n_idx   = '0;
                    n_state = pcpe_pkg::ST_DATA;
                end
            end
            pcpe_pkg::ST_DATA: begin
                if (load) begin
                    emit   = 1'b1;
                    e_byte = rd_data;
                    n_idx  = idx_nxt;
                    if (idx_nxt == r_len) begin
                        n_state = pcpe_pkg::ST_PAD1;
                    end else begin
                        // fetch the next index while the current one is emitted
                        rd_en   = 1'b1;
                        rd_addr = idx_nxt[AW-1:0];
                    end
                end
            end
            pcpe_pkg::ST_PAD1: begin
                if (load) begin
                    emit     = 1'b1;
                    e_eob    = !r_term;
                    n_in_run = 1'b0;
                    n_len    = '0;
                    n_state  = r_term ? pcpe_pkg::ST_TERM : pcpe_pkg::ST_IDLE;
                end
            end
            pcpe_pkg::ST_TERM: begin
                if (load) begin
                    emit     = 1'b1;
                    e_byte   = pcpe_pkg::TERM_BYTE;
                    e_eob    = 1'b1;
                    e_eoc    = 1'b1;
                    n_start  = '0;
                    n_len    = '0;
                    n_in_run = 1'b0;
                    n_term   = 1'b0;
                    n_state  = pcpe_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pcpe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pcpe_pkg::ST_IDLE;
            r_row    <= '0;
            r_start  <= '0;
            r_len    <= '0;
            r_idx    <= '0;
            r_in_run <= 1'b0;
            r_term   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_row    <= n_row;
            r_start  <= n_start;
            r_len    <= n_len;
            r_idx    <= n_idx;
            r_in_run <= n_in_run;
            r_term   <= n_term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_byte.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= e_byte;
            r_out_eob  <= e_eob;
            r_out_eoc  <= e_eoc;
        end
    end

    assign o_byte.valid         = r_out_valid;
    assign o_byte.out_byte      = r_out_byte;
    assign o_byte.end_of_burst  = r_out_eob;
    assign o_byte.end_of_column = r_out_eoc;

endmodule
